/* design/elam_pkg.sv */
// Shared types and constants for the edge list to adjacency matrix block.
`default_nettype none

package elam_pkg;

  localparam int LABEL_W = 32;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  localparam int ROW_W   = 64;
  localparam int DEPTH   = 64;

  typedef struct packed {
    logic signed [LABEL_W-1:0] from_label;
    logic signed [LABEL_W-1:0] to_label;
    logic                      last_edge;
  } edge_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] row_index;
    logic [ROW_W-1:0] row_bits;
    logic [CNT_W-1:0] vertex_total;
    logic             overflow_flag;
    logic             last_row;
  } row_req_t;

  typedef struct packed {
    logic             done;
    logic             from_found;
    logic [IDX_W-1:0] from_idx;
    logic             to_found;
    logic [IDX_W-1:0] to_idx;
  } lookup_res_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [LABEL_W-1:0] wr_data;
  } label_wr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ASSIGN,
    ST_WRITE_B,
    ST_RD_U,
    ST_WR_U,
    ST_RD_V,
    ST_WR_V,
    ST_END,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_t;

endpackage

`default_nettype wire

/* design/elam_lookup.sv */
// Label memory and the sequential scan that maps both labels of an edge to indices.
`default_nettype none

module elam_lookup (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            start,
  input  wire [elam_pkg::LABEL_W-1:0]    from_label,
  input  wire [elam_pkg::LABEL_W-1:0]    to_label,
  input  wire [elam_pkg::CNT_W-1:0]      count,
  input  elam_pkg::label_wr_t            wr,
  output elam_pkg::lookup_res_t          res
);
  import elam_pkg::*;

  logic [LABEL_W-1:0] label_mem [DEPTH];
  logic [LABEL_W-1:0] rdata;
  logic [IDX_W-1:0]   raddr;

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic               pend;
  logic [IDX_W-1:0]   pend_idx;
  logic               fu;
  logic [IDX_W-1:0]   ui;
  logic               fv;
  logic [IDX_W-1:0]   vi;
  logic               more;
  logic               done;

  assign raddr = cnt[IDX_W-1:0];
  assign more  = cnt < count;
  assign done  = busy && !pend && !more;

  always_ff @(posedge clk) begin
    if (wr.wr_en) begin
      label_mem[wr.wr_addr] <= wr.wr_data;
    end
    rdata <= label_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pend <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      pend <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      pend <= more;
      if (more) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx <= raddr;
    if (start) begin
      fu <= 1'b0;
      fv <= 1'b0;
      ui <= '0;
      vi <= '0;
    end else if (busy && pend) begin
      if (!fu && rdata == from_label) begin
        fu <= 1'b1;
        ui <= pend_idx;
      end
      if (!fv && rdata == to_label) begin
        fv <= 1'b1;
        vi <= pend_idx;
      end
    end
  end

  assign res.done       = done;
  assign res.from_found = fu;
  assign res.from_idx   = ui;
  assign res.to_found   = fv;
  assign res.to_idx     = vi;

endmodule

`default_nettype wire

/* design/edge_list_to_adjacency_matrix.sv */
// Top level: relabels edge endpoints and builds the adjacency bit matrix, then streams its rows.
//
// Edges are taken one at a time. Each edge scans the label memory one entry per cycle,
// and holds the input stalled through its scan, index assignment and adjacency updates.
// On an edge marked last the rows are sent out one by one, each by an adjacency memory
// read and then an output register load, then the graph state is cleared at once
// through per-row valid bits. The next edge is accepted while the final row still waits
// in the output register. The directed_mode register, directed, is to be written only
// while the block is idle; the block itself does not enforce it.
`default_nettype none

module edge_list_to_adjacency_matrix #(
  parameter int MAX_VERTICES = 64
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_write,
  input  wire                  cfg_data,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  elam_pkg::edge_req_t  in_req,
  output logic                 out_valid,
  input  wire                  out_stall,
  output elam_pkg::row_req_t   out_req
);
  import elam_pkg::*;

  state_t             state;
  state_t             state_next;

  edge_req_t          edge_r;
  logic               directed;
  logic [CNT_W-1:0]   count;
  logic               overflow;
  logic [DEPTH-1:0]   row_valid;
  logic [IDX_W-1:0]   u_r;
  logic [IDX_W-1:0]   v_r;
  logic               wr_b;
  logic [IDX_W-1:0]   e;

  logic [ROW_W-1:0]   adj_mem [DEPTH];
  logic [ROW_W-1:0]   adj_rdata;
  logic [IDX_W-1:0]   adj_raddr;
  logic [IDX_W-1:0]   adj_raddr_q;
  logic               adj_we;
  logic [IDX_W-1:0]   adj_waddr;
  logic [ROW_W-1:0]   adj_wdata;
  logic [ROW_W-1:0]   adj_row;

  label_wr_t          lwr;
  lookup_res_t        res;
  logic               accept;
  logic               same;
  logic [1:0]         need;
  logic [CNT_W:0]     total;
  logic               ovf;
  logic [IDX_W-1:0]   u_new;
  logic [IDX_W-1:0]   v_new;
  logic               out_free;
  logic               last_emit;

  assign in_stall  = state != ST_IDLE;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign last_emit = (CNT_W'(e) + CNT_W'(1)) == count;

  elam_lookup u_lookup (
    .clk        (clk),
    .rst        (rst),
    .start      (accept),
    .from_label (edge_r.from_label),
    .to_label   (edge_r.to_label),
    .count      (count),
    .wr         (lwr),
    .res        (res)
  );

  // new-index assignment
  assign same  = edge_r.from_label == edge_r.to_label;
  assign need  = {1'b0, !res.from_found}
               + {1'b0, !res.to_found && !(!res.from_found && same)};
  assign total = {1'b0, count} + (CNT_W+1)'(need);
  assign ovf   = total > (CNT_W+1)'(MAX_VERTICES);
  assign u_new = res.from_found ? res.from_idx : count[IDX_W-1:0];
  assign v_new = res.to_found ? res.to_idx :
                 same ? u_new : count[IDX_W-1:0] + IDX_W'(!res.from_found);

  assign adj_row = row_valid[adj_raddr_q] ? adj_rdata : '0;

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    adj_rdata   <= adj_mem[adj_raddr];
    adj_raddr_q <= adj_raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    adj_raddr  = e;
    adj_we     = 1'b0;
    adj_waddr  = u_r;
    adj_wdata  = adj_row | (ROW_W'(1) << v_r);
    lwr.wr_en   = 1'b0;
    lwr.wr_addr = count[IDX_W-1:0];
    lwr.wr_data = edge_r.from_label;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (res.done) begin
          state_next = ST_ASSIGN;
        end
      end
      ST_ASSIGN: begin
        if (ovf) begin
          state_next = ST_END;
        end else begin
          lwr.wr_en  = !res.from_found;
          state_next = ST_WRITE_B;
        end
      end
      ST_WRITE_B: begin
        lwr.wr_en   = wr_b;
        lwr.wr_addr = v_r;
        lwr.wr_data = edge_r.to_label;
        state_next  = (u_r != v_r) ? ST_RD_U : ST_END;
      end
      ST_RD_U: begin
        adj_raddr  = u_r;
        state_next = ST_WR_U;
      end
      ST_WR_U: begin
        adj_we     = 1'b1;
        state_next = directed ? ST_END : ST_RD_V;
      end
      ST_RD_V: begin
        adj_raddr  = v_r;
        state_next = ST_WR_V;
      end
      ST_WR_V: begin
        adj_we     = 1'b1;
        adj_waddr  = v_r;
        adj_wdata  = adj_row | (ROW_W'(1) << u_r);
        state_next = ST_END;
      end
      ST_END: begin
        if (edge_r.last_edge && count != '0) begin
          state_next = ST_EMIT_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        if (out_free) begin
          state_next = ST_EMIT_LD;
        end
      end
      ST_EMIT_LD: begin
        state_next = last_emit ? ST_IDLE : ST_EMIT_RD;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      edge_r <= in_req;
    end
    if (state == ST_ASSIGN) begin
      u_r  <= u_new;
      v_r  <= v_new;
      wr_b <= !res.to_found && !same;
    end
    if (state == ST_END) begin
      e <= '0;
    end else if (state == ST_EMIT_LD) begin
      e <= e + IDX_W'(1);
    end
    if (state == ST_EMIT_LD) begin
      out_req.row_index     <= e;
      out_req.row_bits      <= adj_row;
      out_req.vertex_total  <= count;
      out_req.overflow_flag <= overflow;
      out_req.last_row      <= last_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      directed  <= 1'b0;
      count     <= '0;
      overflow  <= 1'b0;
      row_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        directed <= cfg_data;
      end
      if (state == ST_EMIT_LD) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_ASSIGN: begin
          if (ovf) begin
            overflow <= 1'b1;
          end else begin
            count <= total[CNT_W-1:0];
          end
        end
        ST_WR_U: begin
          row_valid[u_r] <= 1'b1;
        end
        ST_WR_V: begin
          row_valid[v_r] <= 1'b1;
        end
        ST_END: begin
          if (edge_r.last_edge && count == '0) begin
            overflow  <= 1'b0;
            row_valid <= '0;
          end
        end
        ST_EMIT_LD: begin
          if (last_emit) begin
            count     <= '0;
            overflow  <= 1'b0;
            row_valid <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire
